### src/lkat_pkg.sv
`default_nettype none
package lkat_pkg;

  localparam int unsigned AccW = 67;
  localparam logic signed [31:0] OneQ16 = 32'sd65536;
  localparam logic signed [67:0] SatMax = 68'sd2147483647;
  localparam logic signed [67:0] SatMin = -68'sd2147483648;

  localparam logic [1:0] RegUpX = 2'd0;
  localparam logic [1:0] RegUpY = 2'd1;
  localparam logic [1:0] RegUpZ = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOVE,
    ST_DIFF,
    ST_NSQ,
    ST_SQRT,
    ST_NDIV,
    ST_CROSS1,
    ST_CROSS2,
    ST_DOT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic               start;
    logic               clr;
    logic               sub;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mac_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > SatMax) begin
      r = 32'sh7fffffff;
    end else if (v < SatMin) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_floor(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] sh;
    sh = acc >>> 16;
    return sat32({sh[AccW-1], sh});
  endfunction

endpackage
`default_nettype wire

### src/lkat_mac.sv
`default_nettype none
module lkat_mac (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire lkat_pkg::mac_req_t             req_i,
  output logic                                done_o,
  output logic signed [lkat_pkg::AccW-1:0]    acc_o
);
  import lkat_pkg::*;

  logic signed [AccW-1:0] acc_q, mcand_q, addend;
  logic [31:0]            mplier_q;
  logic [4:0]             cnt_q;
  logic                   busy_q, done_q, sub_q, neg;

  assign neg    = sub_q ^ (cnt_q == 5'd31);
  assign addend = mplier_q[0] ? (neg ? -mcand_q : mcand_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      if (req_i.clr) begin
        acc_q <= '0;
      end
      mcand_q  <= {{(AccW-32){req_i.a[31]}}, req_i.a};
      mplier_q <= req_i.b;
      sub_q    <= req_i.sub;
    end else if (busy_q) begin
      acc_q    <= acc_q + addend;
      mcand_q  <= mcand_q <<< 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule
`default_nettype wire

### src/lkat_sqrt.sv
`default_nettype none
module lkat_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] rad_i,
  output logic             done_o,
  output logic [31:0]      root_o
);

  logic [63:0] rad_q;
  logic [34:0] rem_q, rem_sh, trial;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q, ge;

  assign rem_sh = {rem_q[32:0], rad_q[63:62]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

### src/lkat_div.sv
`default_nettype none
module lkat_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [47:0] num_i,
  input  wire logic [31:0] den_i,
  output logic             done_o,
  output logic [47:0]      quo_o
);

  logic [47:0] num_q;
  logic [31:0] den_q, rem_q;
  logic [32:0] rem_sh, diff;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q, ge;

  assign rem_sh = {rem_q, num_q[47]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign diff   = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd47) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[46:0], ge};
      rem_q <= ge ? diff[31:0] : rem_sh[31:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule
`default_nettype wire

### src/camera_look_at_view_matrix_unit.sv
// Camera view-matrix unit, signed Q16.16. Each accepted word either loads eye and
// target (action 0) or moves both along the stored camera axes (action 1); the
// unit then rebuilds the forward, right and up axes and returns four row words,
// row 3 carrying the translation. One word is taken at a time: the input stalls
// until all four row words have been handed over. The work is done by the
// bit-serial 32x32 multiply-accumulate unit (27 products for a set and 36
// for a move), up to two square roots and up to six divisions for the
// normalizations.
`default_nettype none
module camera_look_at_view_matrix_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               action_i,
  input  wire logic signed [31:0] px_i,
  input  wire logic signed [31:0] py_i,
  input  wire logic signed [31:0] pz_i,
  input  wire logic signed [31:0] qx_i,
  input  wire logic signed [31:0] qy_i,
  input  wire logic signed [31:0] qz_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              row_index_o,
  output logic signed [31:0]      col0_o,
  output logic signed [31:0]      col1_o,
  output logic signed [31:0]      col2_o,
  output logic signed [31:0]      col3_o,
  output logic                    degenerate_o,
  output logic                    last_row_o
);
  import lkat_pkg::*;

  state_e state_q, state_d;
  logic [1:0] i_q, j_q, row_q, i1, i2;
  logic wait_q, norm_sel_q, degen_q;
  logic signed [31:0] up_q [3];
  logic signed [31:0] eye_q [3];
  logic signed [31:0] tgt_q [3];
  logic signed [31:0] rgt_q [3];
  logic signed [31:0] upa_q [3];
  logic signed [31:0] fwd_q [3];
  logic signed [31:0] dif_q [3];
  logic signed [31:0] trn_q [3];
  logic signed [31:0] p_q [3];
  logic [31:0] len_q;

  mac_req_t mac_req;
  logic mac_done, sqrt_done, div_done, sqrt_start, div_start;
  logic signed [AccW-1:0] acc;
  logic [31:0] root, dif_mag;
  logic [47:0] quo;
  logic in_acc, out_acc, cfg_wr, issue, fin, j_last, acc_zero;
  logic signed [AccW-1:0] off;
  logic signed [31:0] qsig, ax_move, ax_dot;

  lkat_mac u_mac (
    .clk_i, .rst_ni, .req_i(mac_req), .done_o(mac_done), .acc_o(acc)
  );
  lkat_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start), .rad_i(acc[63:0]),
    .done_o(sqrt_done), .root_o(root)
  );
  lkat_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i({dif_mag, 16'h0000}),
    .den_i(len_q), .done_o(div_done), .quo_o(quo)
  );

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_o && !out_stall_i;
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign i1       = (i_q == 2'd2) ? 2'd0 : i_q + 2'd1;
  assign i2       = (i_q == 2'd0) ? 2'd2 : i_q - 2'd1;
  assign acc_zero = (acc == '0);
  assign off      = acc >>> 16;
  assign dif_mag  = dif_q[i_q][31] ? 32'(-dif_q[i_q]) : dif_q[i_q];
  assign qsig     = dif_q[i_q][31] ? -quo[31:0] : quo[31:0];
  assign j_last   = (state_q == ST_CROSS1 || state_q == ST_CROSS2) ? (j_q == 2'd1)
                                                                   : (j_q == 2'd2);

  always_comb begin
    case (j_q)
      2'd0:    ax_move = rgt_q[i_q];
      2'd1:    ax_move = upa_q[i_q];
      default: ax_move = fwd_q[i_q];
    endcase
    case (i_q)
      2'd0:    ax_dot = rgt_q[j_q];
      2'd1:    ax_dot = upa_q[j_q];
      default: ax_dot = fwd_q[j_q];
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = action_i ? ST_MOVE : ST_DIFF;
      ST_MOVE:   if (fin && j_last && i_q == 2'd2) state_d = ST_DIFF;
      ST_DIFF:   state_d = ST_NSQ;
      ST_NSQ: begin
        if (fin && j_last) begin
          if (!acc_zero) state_d = ST_SQRT;
          else state_d = norm_sel_q ? ST_CROSS2 : ST_CROSS1;
        end
      end
      ST_SQRT:   if (fin) state_d = ST_NDIV;
      ST_NDIV:   if (fin && i_q == 2'd2) state_d = norm_sel_q ? ST_CROSS2 : ST_CROSS1;
      ST_CROSS1: if (fin && j_last && i_q == 2'd2) state_d = ST_NSQ;
      ST_CROSS2: if (fin && j_last && i_q == 2'd2) state_d = ST_DOT;
      ST_DOT:    if (fin && j_last && i_q == 2'd2) state_d = ST_OUT;
      ST_OUT:    if (out_acc && row_q == 2'd3) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mac_req     = '0;
    sqrt_start  = 1'b0;
    div_start   = 1'b0;
    issue       = 1'b0;
    fin         = 1'b0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_MOVE, ST_NSQ, ST_CROSS1, ST_CROSS2, ST_DOT: begin
        issue         = !wait_q;
        fin           = wait_q && mac_done;
        mac_req.start = !wait_q;
        mac_req.clr   = (j_q == 2'd0);
        unique case (state_q)
          ST_MOVE: begin
            mac_req.a = ax_move;
            mac_req.b = p_q[j_q];
          end
          ST_NSQ: begin
            mac_req.a = dif_q[j_q];
            mac_req.b = dif_q[j_q];
          end
          ST_CROSS1: begin
            mac_req.sub = (j_q == 2'd1);
            mac_req.a   = (j_q == 2'd0) ? up_q[i1] : up_q[i2];
            mac_req.b   = (j_q == 2'd0) ? fwd_q[i2] : fwd_q[i1];
          end
          ST_CROSS2: begin
            mac_req.sub = (j_q == 2'd1);
            mac_req.a   = (j_q == 2'd0) ? fwd_q[i1] : fwd_q[i2];
            mac_req.b   = (j_q == 2'd0) ? rgt_q[i2] : rgt_q[i1];
          end
          default: begin
            mac_req.sub = 1'b1;
            mac_req.a   = ax_dot;
            mac_req.b   = eye_q[j_q];
          end
        endcase
      end
      ST_SQRT: begin
        issue      = !wait_q;
        fin        = wait_q && sqrt_done;
        sqrt_start = !wait_q;
      end
      ST_NDIV: begin
        issue     = !wait_q;
        fin       = wait_q && div_done;
        div_start = !wait_q;
      end
      ST_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      i_q        <= '0;
      j_q        <= '0;
      row_q      <= '0;
      wait_q     <= 1'b0;
      norm_sel_q <= 1'b0;
      degen_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (issue) begin
        wait_q <= 1'b1;
      end else if (fin) begin
        wait_q <= 1'b0;
      end
      if (in_acc) begin
        i_q        <= '0;
        j_q        <= '0;
        row_q      <= '0;
        norm_sel_q <= 1'b0;
        degen_q    <= 1'b0;
      end
      if (fin) begin
        unique case (state_q)
          ST_NSQ: begin
            j_q <= j_last ? 2'd0 : j_q + 2'd1;
            if (j_last && acc_zero) degen_q <= 1'b1;
          end
          ST_NDIV: i_q <= (i_q == 2'd2) ? 2'd0 : i_q + 2'd1;
          ST_MOVE, ST_CROSS1, ST_CROSS2, ST_DOT: begin
            if (j_last) begin
              j_q <= 2'd0;
              i_q <= (i_q == 2'd2) ? 2'd0 : i_q + 2'd1;
            end else begin
              j_q <= j_q + 2'd1;
            end
          end
          default: ;
        endcase
      end
      if (state_q == ST_CROSS1 && fin && j_last && i_q == 2'd2) norm_sel_q <= 1'b1;
      if (out_acc) row_q <= row_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q[0] <= '0;
      up_q[1] <= OneQ16;
      up_q[2] <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegUpX:  up_q[0] <= pwdata;
        RegUpY:  up_q[1] <= pwdata;
        RegUpZ:  up_q[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegUpX:  prdata = up_q[0];
      RegUpY:  prdata = up_q[1];
      RegUpZ:  prdata = up_q[2];
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        eye_q[k] <= '0;
        tgt_q[k] <= '0;
        rgt_q[k] <= '0;
        upa_q[k] <= '0;
        fwd_q[k] <= '0;
      end
    end else begin
      if (in_acc && !action_i) begin
        eye_q[0] <= px_i;
        eye_q[1] <= py_i;
        eye_q[2] <= pz_i;
        tgt_q[0] <= qx_i;
        tgt_q[1] <= qy_i;
        tgt_q[2] <= qz_i;
      end
      if (state_q == ST_MOVE && fin && j_last) begin
        eye_q[i_q] <= sat32({{36{eye_q[i_q][31]}}, eye_q[i_q]} + {off[AccW-1], off});
        tgt_q[i_q] <= sat32({{36{tgt_q[i_q][31]}}, tgt_q[i_q]} + {off[AccW-1], off});
      end
      if (state_q == ST_NSQ && fin && j_last && acc_zero) begin
        for (int k = 0; k < 3; k++) begin
          if (norm_sel_q) rgt_q[k] <= '0;
          else fwd_q[k] <= '0;
        end
      end
      if (state_q == ST_NDIV && fin) begin
        if (norm_sel_q) rgt_q[i_q] <= qsig;
        else fwd_q[i_q] <= qsig;
      end
      if (state_q == ST_CROSS2 && fin && j_last) upa_q[i_q] <= sat_floor(acc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p_q[0] <= px_i;
      p_q[1] <= py_i;
      p_q[2] <= pz_i;
    end
    if (state_q == ST_DIFF) begin
      for (int k = 0; k < 3; k++) begin
        dif_q[k] <= sat32({{36{eye_q[k][31]}}, eye_q[k]} - {{36{tgt_q[k][31]}}, tgt_q[k]});
      end
    end
    if (state_q == ST_CROSS1 && fin && j_last) dif_q[i_q] <= sat_floor(acc);
    if (state_q == ST_SQRT && fin) len_q <= root;
    if (state_q == ST_DOT && fin && j_last) trn_q[i_q] <= sat_floor(acc);
  end

  always_comb begin
    case (row_q)
      2'd0: begin
        col0_o = rgt_q[0];
        col1_o = upa_q[0];
        col2_o = fwd_q[0];
        col3_o = '0;
      end
      2'd1: begin
        col0_o = rgt_q[1];
        col1_o = upa_q[1];
        col2_o = fwd_q[1];
        col3_o = '0;
      end
      2'd2: begin
        col0_o = rgt_q[2];
        col1_o = upa_q[2];
        col2_o = fwd_q[2];
        col3_o = '0;
      end
      default: begin
        col0_o = trn_q[0];
        col1_o = trn_q[1];
        col2_o = trn_q[2];
        col3_o = OneQ16;
      end
    endcase
  end

  assign row_index_o  = row_q;
  assign degenerate_o = degen_q;
  assign last_row_o   = (row_q == 2'd3);

endmodule
`default_nettype wire

### src/lkat_chk.sv
`default_nettype none
module lkat_chk (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [1:0]         row_index_o,
  input wire logic signed [31:0] col0_o,
  input wire logic signed [31:0] col3_o,
  input wire logic               last_row_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(row_index_o) && $stable(col0_o))
    else $error("stalled output word changed");

  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_row_o == (row_index_o == 2'd3)))
    else $error("last_row does not match row 3");

  a_col3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((row_index_o == 2'd3) ? (col3_o == 32'sd65536) : (col3_o == 32'sd0)))
    else $error("column 3 wrong for row");

  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_row_o |=> !out_valid_o && !in_stall_o)
    else $error("unit not idle after last row");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o)
    else $error("unit took a word while busy");

endmodule

bind camera_look_at_view_matrix_unit lkat_chk u_lkat_chk (.*);
`default_nettype wire

### verif/camera_look_at_view_matrix_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module camera_look_at_view_matrix_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  input  wire logic               pready,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic               action_i,
  input  wire logic signed [31:0] px_i,
  input  wire logic signed [31:0] py_i,
  input  wire logic signed [31:0] pz_i,
  input  wire logic signed [31:0] qx_i,
  input  wire logic signed [31:0] qy_i,
  input  wire logic signed [31:0] qz_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic [1:0]         row_index_i,
  input  wire logic signed [31:0] col0_i,
  input  wire logic signed [31:0] col1_i,
  input  wire logic signed [31:0] col2_i,
  input  wire logic signed [31:0] col3_i,
  input  wire logic               degenerate_i,
  input  wire logic               last_row_i,
  output int                      fail_count_o,
  output int                      pending_rows_o,
  output int                      rows_seen_o,
  output int                      degen_seen_o
);
  import lkat_pkg::*;

  localparam logic action_set = 1'b0;

  typedef struct packed {
    logic [1:0]         row;
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] c3;
    logic               degen;
    logic               last;
  } row_word_t;

  typedef logic signed [31:0] vec3_t [3];

  row_word_t   row_queue[$];
  logic signed [31:0] up_vec[3];
  vec3_t eye, tgt, ax_r, ax_u, ax_f;

  function automatic logic signed [31:0] clip32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] fl16(input logic signed [127:0] v);
    return v >>> 16;
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic unit_vec(input vec3_t v, output vec3_t o);
    logic [63:0] m[3];
    logic [63:0] sum, len, q;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? 64'(-$signed(65'(v[i]))) : 64'(v[i]);
      sum += m[i] * m[i];
    end
    if (sum == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return 1'b1;
    end
    len = root64(sum);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] << 16) / len;
      o[i] = v[i] < 0 ? -q[31:0] : q[31:0];
    end
    return 1'b0;
  endfunction

  function automatic logic signed [127:0] mul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return 128'(a) * 128'(b);
  endfunction

  function automatic void cross_q16(input vec3_t a, input vec3_t b, output vec3_t o);
    o[0] = clip32(fl16(mul(a[1], b[2]) - mul(a[2], b[1])));
    o[1] = clip32(fl16(mul(a[2], b[0]) - mul(a[0], b[2])));
    o[2] = clip32(fl16(mul(a[0], b[1]) - mul(a[1], b[0])));
  endfunction

  function automatic logic signed [31:0] neg_dot(input vec3_t a, input vec3_t b);
    return clip32(fl16(-(mul(a[0], b[0]) + mul(a[1], b[1]) + mul(a[2], b[2]))));
  endfunction

  task automatic predict_rows(input logic act, input vec3_t p, input vec3_t q);
    vec3_t diff, upc;
    logic signed [127:0] off;
    logic d1, d2;
    row_word_t w;
    if (act == action_set) begin
      eye = p;
      tgt = q;
    end else begin
      for (int i = 0; i < 3; i++) begin
        off = fl16(mul(ax_r[i], p[0]) + mul(ax_u[i], p[1]) + mul(ax_f[i], p[2]));
        eye[i] = clip32(128'(eye[i]) + off);
        tgt[i] = clip32(128'(tgt[i]) + off);
      end
    end
    for (int i = 0; i < 3; i++) diff[i] = clip32(128'(eye[i]) - 128'(tgt[i]));
    d1 = unit_vec(diff, ax_f);
    upc = up_vec;
    cross_q16(upc, ax_f, diff);
    d2 = unit_vec(diff, ax_r);
    cross_q16(ax_f, ax_r, ax_u);
    for (int r = 0; r < 4; r++) begin
      w.row = r[1:0];
      w.degen = d1 | d2;
      w.last = (r == 3);
      if (r < 3) begin
        w.c0 = ax_r[r];
        w.c1 = ax_u[r];
        w.c2 = ax_f[r];
        w.c3 = 0;
      end else begin
        w.c0 = neg_dot(ax_r, eye);
        w.c1 = neg_dot(ax_u, eye);
        w.c2 = neg_dot(ax_f, eye);
        w.c3 = OneQ16;
      end
      row_queue.push_back(w);
    end
  endtask

  assign pending_rows_o = row_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    vec3_t p, q;
    row_word_t got, want;
    if (!rst_ni) begin
      up_vec = '{0, 65536, 0};
      eye = '{0, 0, 0};
      tgt = '{0, 0, 0};
      ax_r = '{0, 0, 0};
      ax_u = '{0, 0, 0};
      ax_f = '{0, 0, 0};
      row_queue.delete();
      fail_count_o <= 0;
      rows_seen_o <= 0;
      degen_seen_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          RegUpX: up_vec[0] = pwdata;
          RegUpY: up_vec[1] = pwdata;
          RegUpZ: up_vec[2] = pwdata;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{row_index_i, col0_i, col1_i, col2_i, col3_i, degenerate_i, last_row_i};
        rows_seen_o <= rows_seen_o + 1;
        if (degenerate_i) degen_seen_o <= degen_seen_o + 1;
        if (row_queue.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected row word %p", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = row_queue.pop_front();
          if (got !== want) begin
            if (fail_count_o < 10) $display("row mismatch: exp %p got %p", want, got);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        p = '{px_i, py_i, pz_i};
        q = '{qx_i, qy_i, qz_i};
        predict_rows(action_i, p, q);
      end
    end
  end
endmodule
`default_nettype wire

### verif/tb_camera_look_at_view_matrix_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_camera_look_at_view_matrix_unit;
  import lkat_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0, in_stall_o;
  logic action_i = 1'b0;
  logic signed [31:0] px_i = 0, py_i = 0, pz_i = 0, qx_i = 0, qy_i = 0, qz_i = 0;
  logic out_valid_o, out_stall_i = 1'b0;
  logic [1:0] row_index_o;
  logic signed [31:0] col0_o, col1_o, col2_o, col3_o;
  logic degenerate_o, last_row_o;
  int fail_count, pending_rows, rows_seen, degen_seen;
  int words_sent = 0;
  int hold_cnt = 0;
  logic hold_go = 1'b0;
  logic hold_used = 1'b0;
  logic stall_mode = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  camera_look_at_view_matrix_unit u_dut (.*);

  camera_look_at_view_matrix_checker u_chk (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_stall_i(in_stall_o), .action_i, .px_i, .py_i, .pz_i,
    .qx_i, .qy_i, .qz_i, .out_valid_i(out_valid_o), .out_stall_i,
    .row_index_i(row_index_o), .col0_i(col0_o), .col1_i(col1_o), .col2_i(col2_o),
    .col3_i(col3_o), .degenerate_i(degenerate_o), .last_row_i(last_row_o),
    .fail_count_o(fail_count), .pending_rows_o(pending_rows),
    .rows_seen_o(rows_seen), .degen_seen_o(degen_seen)
  );

  always @(posedge clk_i) begin
    if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_cnt <= 3000;
      out_stall_i <= 1'b1;
    end else if (hold_cnt > 0) begin
      out_stall_i <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (stall_mode) begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_up(input logic [31:0] ux, input logic [31:0] uy,
                        input logic [31:0] uz);
    reg_write(RegUpX, ux);
    reg_write(RegUpY, uy);
    reg_write(RegUpZ, uz);
  endtask

  task automatic send_word(input logic act, input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] c, input logic [31:0] d,
                           input logic [31:0] e, input logic [31:0] f);
    in_valid_i <= 1'b1;
    action_i <= act;
    px_i <= a; py_i <= b; pz_i <= c;
    qx_i <= d; qy_i <= e; qz_i <= f;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic idle_gap();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 40)) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_rows != 0) @(posedge clk_i);
    repeat (1500) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
    endcase
  endfunction

  function automatic logic [31:0] rand_up();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'h00010000;
      2: return 32'hffff0000;
      default: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
    endcase
  endfunction

  task automatic random_phase(input int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 6);
      while (burst > 0 && count > 0) begin
        send_word($urandom_range(0, 2) != 0 ? 1'b1 : 1'b0,
                  rand_pos(), rand_pos(), rand_pos(),
                  rand_pos(), rand_pos(), rand_pos());
        burst--;
        count--;
      end
      if ($urandom_range(0, 3) != 0) idle_gap();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_word(1'b1, 32'h00010000, 32'h00010000, 32'h00010000, 0, 0, 0);
    send_word(1'b0, 0, 0, 0, 0, 0, 0);
    send_word(1'b0, 32'h00050000, 32'h00020000, 32'h000a0000, 0, 0, 0);
    send_word(1'b1, 32'h00010000, 32'hffff0000, 32'h00020000, 1, 2, 3);
    send_word(1'b0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h80000000, 32'h80000000, 32'h80000000);
    send_word(1'b0, 32'h80000000, 0, 0, 32'h7fffffff, 0, 0);
    send_word(1'b0, 0, 32'h00030000, 0, 0, 0, 0);
    send_word(1'b0, 32'h7fff0000, 32'h7fff0000, 32'h7fff0000, 0, 0, 1);
    send_word(1'b1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
    send_word(1'b1, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0);
    send_word(1'b0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0);
    send_word(1'b0, 1, 0, 0, 0, 0, 0);
    drain();
    set_up(0, 0, 0);
    send_word(1'b0, 32'h00010000, 32'h00020000, 32'h00030000, 0, 0, 0);
    drain();
    set_up(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_word(1'b0, 32'h00010000, 32'h00020000, 32'h00030000, 0, 0, 0);
    send_word(1'b1, 32'h00010000, 32'h00010000, 32'h00010000, 0, 0, 0);
    stall_mode = 1'b1;
    hold_go = 1'b1;
    random_phase(20);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      set_up(rand_up(), rand_up(), rand_up());
      stall_mode = ph[0];
      random_phase(95);
      drain();
    end
    repeat (1000) @(posedge clk_i);
    $display("sent %0d words, checked %0d row words, %0d degenerate",
             words_sent, rows_seen, degen_seen);
    $display("covered set/move, saturation extremes, zero vectors, several up vectors");
    if (fail_count == 0 && pending_rows == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
